// ===== design/llcp_pkg.sv =====
// Shared types and constants for the laser line column peak range block.
`default_nettype none

package llcp_pkg;

  localparam int ColW   = 10;
  localparam int RowW   = 10;
  localparam int ChanW  = 8;
  localparam int SumW   = 10;
  localparam int DimW   = 11;
  localparam int NumW   = 24;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;
  localparam int MaxWidth = 1024;

  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRangeNum    = 2'd2;

  localparam logic [DimW-1:0] FrameWidthRst  = 11'd640;
  localparam logic [DimW-1:0] FrameHeightRst = 11'd480;
  localparam logic [NumW-1:0] RangeNumRst    = 24'd1044480;

  typedef struct packed {
    logic [ColW-1:0]  pixel_column;
    logic [RowW-1:0]  pixel_row;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [ColW-1:0] out_column;
    logic [RowW-1:0] peak_row;
    logic [NumW-1:0] distance_q4;
    logic            last_column;
  } result_t;

  // Column summary handed from the peak tracker to the range divider.
  typedef struct packed {
    logic [ColW-1:0] column;
    logic [RowW-1:0] peak_row;
    logic            last_column;
    logic            saturate;
    logic [DimW-1:0] denom;
  } emit_t;

endpackage

`default_nettype wire

// ===== design/laser_line_column_peak_range.sv =====
// Ordinary pixel: updates its column entry in the cycle after acceptance, no result.
// Last-row pixel: its column summary goes from the stage-1 registers through the divider into the output register.
// Throughput: one pixel per cycle off the last row while the divider is idle; a last-row pixel
// holds the input until the bit-serial 24-bit distance divider has handed its result on.
// Peak memory needs no clearing pass.
// Synchronous active-low reset restores the configuration registers and empties the pipe.
`default_nettype none

module laser_line_column_peak_range (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire llcp_pkg::pixel_t                in_pixel,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output llcp_pkg::result_t                    out_result,
  input  wire logic                            cfg_we,
  input  wire logic [llcp_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [llcp_pkg::CfgDataW-1:0]   cfg_data
);

  logic [llcp_pkg::DimW-1:0] frame_width_r;
  logic [llcp_pkg::DimW-1:0] frame_height_r;
  logic [llcp_pkg::NumW-1:0] range_num_r;

  logic                      out_valid_r;
  llcp_pkg::result_t         out_result_r;

  logic                      acc;
  logic                      emit_valid;
  llcp_pkg::emit_t           emit;
  logic                      div_busy;
  logic                      div_valid;
  logic                      div_take;
  llcp_pkg::result_t         div_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= llcp_pkg::FrameWidthRst;
      frame_height_r <= llcp_pkg::FrameHeightRst;
      range_num_r    <= llcp_pkg::RangeNumRst;
    end else if (cfg_we) begin
      case (cfg_index)
        llcp_pkg::CfgFrameWidth:  frame_width_r  <= cfg_data[llcp_pkg::DimW-1:0];
        llcp_pkg::CfgFrameHeight: frame_height_r <= cfg_data[llcp_pkg::DimW-1:0];
        llcp_pkg::CfgRangeNum:    range_num_r    <= cfg_data[llcp_pkg::NumW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Hold input while a last-row pixel waits for or occupies the divider.
  always_comb begin
    in_ready = !div_busy && !emit_valid;
    acc      = in_valid && in_ready;
    div_take = div_valid && (!out_valid_r || out_ready);
  end

  llcp_peak_track u_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .pixel        (in_pixel),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .emit_valid   (emit_valid),
    .emit         (emit)
  );

  llcp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (emit_valid),
    .emit      (emit),
    .numer     (range_num_r),
    .busy      (div_busy),
    .res_valid (div_valid),
    .res_ready (div_take),
    .res       (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_take) begin
      out_result_r <= div_res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

`default_nettype wire

// ===== design/llcp_peak_track.sv =====
// Per-column peak memory with read-modify-write update and forwarding.
`default_nettype none

module llcp_peak_track (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        acc,
  input  wire llcp_pkg::pixel_t            pixel,
  input  wire logic [llcp_pkg::DimW-1:0]   frame_width,
  input  wire logic [llcp_pkg::DimW-1:0]   frame_height,
  output logic                             emit_valid,
  output llcp_pkg::emit_t                  emit
);

  localparam int EntW = llcp_pkg::SumW + llcp_pkg::RowW;

  logic [EntW-1:0] mem [llcp_pkg::MaxWidth];

  logic                        s1_valid_r;
  logic [llcp_pkg::ColW-1:0]   s1_col_r;
  logic [llcp_pkg::RowW-1:0]   s1_row_r;
  logic [llcp_pkg::SumW-1:0]   s1_sum_r;
  logic [EntW-1:0]             rd_data_r;
  logic                        fwd_valid_r;
  logic [EntW-1:0]             fwd_data_r;

  logic                        in_frame;
  logic [llcp_pkg::SumW-1:0]   pix_sum;
  logic [EntW-1:0]             old_ent;
  logic [llcp_pkg::SumW-1:0]   old_sum;
  logic [llcp_pkg::SumW-1:0]   new_sum;
  logic [llcp_pkg::RowW-1:0]   new_row;
  logic [EntW-1:0]             wr_data;

  always_comb begin
    in_frame = ({1'b0, pixel.pixel_column} < frame_width) &&
               ({1'b0, pixel.pixel_row} < frame_height);
    pix_sum  = {2'b00, pixel.red} + {2'b00, pixel.green} + {2'b00, pixel.blue};
  end

  // Take the entry written last cycle when the memory read raced it.
  always_comb begin
    old_ent = fwd_valid_r ? fwd_data_r : rd_data_r;
    old_sum = old_ent[EntW-1 -: llcp_pkg::SumW];
    new_sum = old_sum;
    new_row = old_ent[llcp_pkg::RowW-1:0];
    if (s1_row_r == '0) begin
      if (s1_sum_r != '0) begin
        new_sum = s1_sum_r;
        new_row = '0;
      end else begin
        new_sum = '0;
        new_row = frame_height[llcp_pkg::DimW-1:1];
      end
    end else if (s1_sum_r > old_sum) begin
      new_sum = s1_sum_r;
      new_row = s1_row_r;
    end
    wr_data = {new_sum, new_row};
  end

  always_comb begin
    emit_valid       = s1_valid_r && ({1'b0, s1_row_r} == (frame_height - 1'b1));
    emit.column      = s1_col_r;
    emit.peak_row    = new_row;
    emit.last_column = ({1'b0, s1_col_r} == (frame_width - 1'b1));
    emit.saturate    = ({1'b0, new_row} >= frame_height);
    emit.denom       = frame_height - {1'b0, new_row};
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      mem[s1_col_r] <= wr_data;
    end
    if (acc) begin
      rd_data_r <= mem[pixel.pixel_column];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= acc && in_frame;
      fwd_valid_r <= acc && s1_valid_r && (s1_col_r == pixel.pixel_column);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= wr_data;
    if (acc) begin
      s1_col_r <= pixel.pixel_column;
      s1_row_r <= pixel.pixel_row;
      s1_sum_r <= pix_sum;
    end
  end

endmodule

`default_nettype wire

// ===== design/llcp_div.sv =====
// Radix-2 restoring divider producing the Q4 distance, one quotient bit per cycle.
`default_nettype none

module llcp_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire llcp_pkg::emit_t             emit,
  input  wire logic [llcp_pkg::NumW-1:0]   numer,
  output logic                             busy,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output llcp_pkg::result_t                res
);

  localparam int CntW = $clog2(llcp_pkg::NumW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t                      state_r;
  logic [CntW-1:0]             cnt_r;
  logic [llcp_pkg::NumW-1:0]   quot_r;
  logic [llcp_pkg::DimW-1:0]   rem_r;
  logic [llcp_pkg::DimW-1:0]   denom_r;
  logic [llcp_pkg::ColW-1:0]   col_r;
  logic [llcp_pkg::RowW-1:0]   peak_r;
  logic                        last_r;

  logic [llcp_pkg::DimW:0]     trial;
  logic                        fits;

  always_comb begin
    trial = {rem_r, quot_r[llcp_pkg::NumW-1]};
    fits  = (trial >= {1'b0, denom_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            col_r   <= emit.column;
            peak_r  <= emit.peak_row;
            last_r  <= emit.last_column;
            denom_r <= emit.denom;
            rem_r   <= '0;
            cnt_r   <= CntW'(llcp_pkg::NumW - 1);
            if (emit.saturate) begin
              quot_r  <= '1;
              state_r <= ST_DONE;
            end else begin
              quot_r  <= numer;
              state_r <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          // Shift in one numerator bit, subtract the divisor when it fits.
          if (fits) begin
            rem_r <= llcp_pkg::DimW'(trial - {1'b0, denom_r});
          end else begin
            rem_r <= trial[llcp_pkg::DimW-1:0];
          end
          quot_r <= {quot_r[llcp_pkg::NumW-2:0], fits};
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    busy            = (state_r != ST_IDLE);
    res_valid       = (state_r == ST_DONE);
    res.out_column  = col_r;
    res.peak_row    = peak_r;
    res.distance_q4 = quot_r;
    res.last_column = last_r;
  end

endmodule

`default_nettype wire
